// File: rtl/core/best_pkg.sv
`default_nettype none

package best_pkg;

    // Shared multiplier operand width
    localparam int MUL_W = 32;

    localparam int CURRENT_W = 16;

    localparam logic [15:0] INTERVAL_RESET = 16'd1000;

    // x / 1000 == (x >> 3) / 125; floor(2^32 / 125)
    localparam logic [31:0] RECIP_125 = 32'd34359738;
    localparam logic [31:0] DIV_125   = 32'd125;

    // mW*ms per mWh; 3600000 == 128 * 28125, floor(2^34 / 28125)
    localparam logic [22:0] MWMS_PER_MWH = 23'd3600000;
    localparam logic [19:0] RECIP_28125  = 20'd610839;

    localparam logic [14:0] PEAK_OUT_MAX = 15'h7FFF;

endpackage

`default_nettype wire

// File: rtl/core/battery_energy_stats_tracker.sv
// Pack statistics tracker.
// Input channel (in_valid / in_stall) carries one pack sample per request;
// output channel (out_valid / out_stall) returns exactly one result per
// request. cfg_wr_en / cfg_wr_data write the poll interval (reset 1000 ms);
// write it only while no request is in flight.
// A sample is taken only in the idle state, so in_stall is high while one is
// being worked on. Every product and constant division (power, uptime,
// energy booking) runs in turn through one registered 32x32 multiplier under
// a one-hot sequencer, which runs extra steps when discharge energy is booked;
// the next sample is taken only once the previous result has been loaded
// into the output register.
// Results sit in an output register: a stalled result holds steady while the
// block already takes and works on the next sample; the new result waits in
// the last sequencer step until the register is free.
// Reset (rst_n, asynchronous) clears all statistics, the ring pointer and the
// sequencer; the current history ring itself is not cleared.
`default_nettype none

module battery_energy_stats_tracker
    import best_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        pack_mv,
    input  wire logic signed [15:0] pack_ma,
    input  wire logic signed [15:0] temp_c,
    input  wire logic               chg_flag,
    input  wire logic [31:0]        now_ms,
    input  wire logic               force_req,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    polled,
    output logic signed [22:0]      pack_mw,
    output logic                    chg_active,
    output logic [31:0]             drained_mwh,
    output logic [15:0]             session_cnt,
    output logic signed [15:0]      max_temp_out,
    output logic signed [15:0]      max_in_ma,
    output logic [14:0]             max_out_ma,
    output logic [22:0]             up_secs,
    output logic                    ring_full
);

    localparam int RING_AW = $clog2(HISTORY_DEPTH);
    localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(HISTORY_DEPTH - 1);

    typedef enum logic [14:0]
    {
        ST_IDLE = 15'h0001,
        ST_PMUL = 15'h0002,
        ST_PDIV = 15'h0004,
        ST_PFIX = 15'h0008,
        ST_PCOR = 15'h0010,
        ST_UFIX = 15'h0020,
        ST_UCOR = 15'h0040,
        ST_EACC = 15'h0080,
        ST_ELO  = 15'h0100,
        ST_EHI  = 15'h0200,
        ST_ESUM = 15'h0400,
        ST_EFIX = 15'h0800,
        ST_ECOR = 15'h1000,
        ST_UPD  = 15'h2000,
        ST_DONE = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration and statistics
    logic [15:0]        interval_reg;
    logic [31:0]        last_tick_reg;
    logic [21:0]        energy_rem_reg;
    logic [31:0]        energy_total_reg;
    logic               was_charging_reg;
    logic [15:0]        session_count_reg;
    logic signed [15:0] peak_temp_reg;
    logic signed [15:0] peak_in_reg;
    logic [14:0]        peak_out_reg;
    logic [RING_AW-1:0] ring_index_reg;
    logic               ring_wrapped_reg;
    logic               out_valid_reg;

    // request being worked on
    logic [15:0]        mv_reg;
    logic [15:0]        ma_reg;
    logic [15:0]        temp_reg;
    logic               chg_reg;
    logic [31:0]        now_reg;
    logic               polled_reg;
    logic [31:0]        gap_reg;
    logic [17:0]        dt_reg;
    logic [27:0]        x_reg;
    logic [21:0]        q_est_reg;
    logic [21:0]        pmag_reg;
    logic [22:0]        u_est_reg;
    logic [22:0]        uptime_reg;
    logic               e_en_reg;
    logic [39:0]        acc_reg;
    logic [35:0]        pl_reg;
    logic [18:0]        q2_reg;

    // result register
    logic               res_polled_reg;
    logic [22:0]        res_power_reg;
    logic               res_charging_reg;
    logic [31:0]        res_energy_reg;
    logic [15:0]        res_sessions_reg;
    logic [15:0]        res_temp_reg;
    logic [15:0]        res_in_reg;
    logic [14:0]        res_out_reg;
    logic [22:0]        res_uptime_reg;
    logic               res_full_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_prod;

    logic               accept;
    logic               load_result;
    logic [31:0]        gap_in;
    logic [15:0]        ma_mag;
    logic               charging;
    logic [27:0]        p_rem;
    logic [28:0]        u_rem;
    logic               e_en;
    logic [53:0]        e_sum;
    logic [22:0]        e_rem;
    logic [22:0]        power_sel;
    logic               ring_we;
    logic [CURRENT_W-1:0] ring_rd_data;

    assign accept      = (state_reg == ST_IDLE) && in_valid;
    assign load_result = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall    = (state_reg != ST_IDLE);

    assign gap_in   = now_ms - last_tick_reg;
    assign ma_mag   = ma_reg[15] ? (~ma_reg + 16'd1) : ma_reg;
    assign charging = chg_reg || (!ma_reg[15] && (ma_reg != 16'd0));

    assign p_rem = x_reg - mul_prod[27:0];
    assign u_rem = now_reg[31:3] - mul_prod[28:0];
    assign e_en  = polled_reg && (last_tick_reg != 32'd0) && ma_reg[15];
    assign e_sum = {mul_prod[37:0], 16'd0} + {18'd0, pl_reg};
    assign e_rem = acc_reg[22:0] - mul_prod[22:0];

    assign power_sel = ma_reg[15] ? (23'd0 - {1'b0, pmag_reg}) : {1'b0, pmag_reg};

    assign ring_we = (state_reg == ST_UPD) && polled_reg;

    best_mul u_mul
    (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (mul_prod)
    );

    // history is write-only here; the read port follows the write pointer
    best_ram #(
        .WIDTH (CURRENT_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring
    (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_index_reg),
        .wr_data (ma_reg),
        .rd_addr (ring_index_reg),
        .rd_data (ring_rd_data)
    );

    // multiplier operands: a step that reads mul_prod uses the product issued by the preceding step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PMUL:
            begin
                mul_a = {16'd0, mv_reg};
                mul_b = {16'd0, ma_mag};
            end
            ST_PDIV:
            begin
                mul_a = {4'd0, mul_prod[30:3]};
                mul_b = RECIP_125;
            end
            ST_PFIX:
            begin
                mul_a = {10'd0, mul_prod[53:32]};
                mul_b = DIV_125;
            end
            ST_PCOR:
            begin
                mul_a = {3'd0, now_reg[31:3]};
                mul_b = RECIP_125;
            end
            ST_UFIX:
            begin
                mul_a = {9'd0, mul_prod[54:32]};
                mul_b = DIV_125;
            end
            ST_UCOR:
            begin
                mul_a = {10'd0, pmag_reg};
                mul_b = {14'd0, dt_reg};
            end
            ST_ELO:
            begin
                mul_a = {16'd0, acc_reg[22:7]};
                mul_b = {12'd0, RECIP_28125};
            end
            ST_EHI:
            begin
                mul_a = {15'd0, acc_reg[39:23]};
                mul_b = {12'd0, RECIP_28125};
            end
            ST_EFIX:
            begin
                mul_a = {13'd0, q2_reg};
                mul_b = {9'd0, MWMS_PER_MWH};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PMUL;
            ST_PMUL: state_next = ST_PDIV;
            ST_PDIV: state_next = ST_PFIX;
            ST_PFIX: state_next = ST_PCOR;
            ST_PCOR: state_next = ST_UFIX;
            ST_UFIX: state_next = ST_UCOR;
            ST_UCOR: state_next = e_en ? ST_EACC : ST_UPD;
            ST_EACC: state_next = ST_ELO;
            ST_ELO:  state_next = ST_EHI;
            ST_EHI:  state_next = ST_ESUM;
            ST_ESUM: state_next = ST_EFIX;
            ST_EFIX: state_next = ST_ECOR;
            ST_ECOR: state_next = ST_UPD;
            ST_UPD:  state_next = ST_DONE;
            ST_DONE: if (load_result) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            interval_reg      <= INTERVAL_RESET;
            last_tick_reg     <= '0;
            energy_rem_reg    <= '0;
            energy_total_reg  <= '0;
            was_charging_reg  <= 1'b0;
            session_count_reg <= '0;
            peak_temp_reg     <= '0;
            peak_in_reg       <= '0;
            peak_out_reg      <= '0;
            ring_index_reg    <= '0;
            ring_wrapped_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end

            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // remainder after the corrected quotient, always below one mWh
            if (state_reg == ST_ECOR)
            begin
                if (e_rem >= MWMS_PER_MWH)
                begin
                    energy_rem_reg <= 22'(e_rem - MWMS_PER_MWH);
                end
                else
                begin
                    energy_rem_reg <= e_rem[21:0];
                end
            end

            if ((state_reg == ST_UPD) && polled_reg)
            begin
                if (e_en_reg)
                begin
                    energy_total_reg <= energy_total_reg + {13'd0, q2_reg};
                end
                if (ring_index_reg == RING_LAST)
                begin
                    ring_index_reg   <= '0;
                    ring_wrapped_reg <= 1'b1;
                end
                else
                begin
                    ring_index_reg <= ring_index_reg + 1'b1;
                end
                if (charging && !was_charging_reg)
                begin
                    session_count_reg <= session_count_reg + 16'd1;
                end
                was_charging_reg <= charging;
                if ($signed(temp_reg) > peak_temp_reg)
                begin
                    peak_temp_reg <= $signed(temp_reg);
                end
                if ($signed(ma_reg) > peak_in_reg)
                begin
                    peak_in_reg <= $signed(ma_reg);
                end
                // discharge magnitude saturates at full scale
                if (ma_reg[15] && (ma_mag > {1'b0, peak_out_reg}))
                begin
                    peak_out_reg <= ma_mag[15] ? PEAK_OUT_MAX : ma_mag[14:0];
                end
                last_tick_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_reg     <= pack_mv;
            ma_reg     <= pack_ma;
            temp_reg   <= temp_c;
            chg_reg    <= chg_flag;
            now_reg    <= now_ms;
            gap_reg    <= gap_in;
            polled_reg <= force_req || (gap_in >= {16'd0, interval_reg});
        end

        case (state_reg)
            ST_PMUL:
            begin
                // long gaps count as one interval
                if (gap_reg > {14'd0, interval_reg, 2'd0})
                begin
                    dt_reg <= {2'd0, interval_reg};
                end
                else
                begin
                    dt_reg <= gap_reg[17:0];
                end
            end
            ST_PDIV:
            begin
                x_reg <= mul_prod[30:3];
            end
            ST_PFIX:
            begin
                q_est_reg <= mul_prod[53:32];
            end
            ST_PCOR:
            begin
                pmag_reg <= q_est_reg + {21'd0, (p_rem >= 28'd125)};
            end
            ST_UFIX:
            begin
                u_est_reg <= mul_prod[54:32];
            end
            ST_UCOR:
            begin
                uptime_reg <= u_est_reg + {22'd0, (u_rem >= 29'd125)};
                e_en_reg   <= e_en;
            end
            ST_EACC:
            begin
                acc_reg <= {18'd0, energy_rem_reg} + mul_prod[39:0];
            end
            ST_EHI:
            begin
                pl_reg <= mul_prod[35:0];
            end
            ST_ESUM:
            begin
                q2_reg <= e_sum[52:34];
            end
            ST_ECOR:
            begin
                if (e_rem >= MWMS_PER_MWH)
                begin
                    q2_reg <= q2_reg + 19'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (load_result)
        begin
            res_polled_reg   <= polled_reg;
            res_power_reg    <= polled_reg ? power_sel : 23'd0;
            res_charging_reg <= polled_reg && charging;
            res_energy_reg   <= energy_total_reg;
            res_sessions_reg <= session_count_reg;
            res_temp_reg     <= peak_temp_reg;
            res_in_reg       <= peak_in_reg;
            res_out_reg      <= peak_out_reg;
            res_uptime_reg   <= uptime_reg;
            res_full_reg     <= ring_wrapped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign polled       = res_polled_reg;
    assign pack_mw      = $signed(res_power_reg);
    assign chg_active   = res_charging_reg;
    assign drained_mwh  = res_energy_reg;
    assign session_cnt  = res_sessions_reg;
    assign max_temp_out = $signed(res_temp_reg);
    assign max_in_ma    = $signed(res_in_reg);
    assign max_out_ma   = res_out_reg;
    assign up_secs      = res_uptime_reg;
    assign ring_full    = res_full_reg;

endmodule

`default_nettype wire

// File: rtl/core/best_mul.sv
`default_nettype none

module best_mul
    import best_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [MUL_W-1:0]     mul_a,
    input  wire logic [MUL_W-1:0]     mul_b,
    output logic      [2*MUL_W-1:0]   prod
);

    logic [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/core/best_ram.sv
`default_nettype none

module best_ram
    import best_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int HIST_DEPTH = 64;
    localparam int unsigned GAP_FACTOR = 4;
    localparam int unsigned MS_IN_S = 1000;
    localparam longint unsigned MWMS_IN_MWH = 3600000;
    localparam int PHASE_ITEMS = 240;
    localparam int SEGMENT_ITEMS = 48;

    typedef struct packed {
        logic [15:0]        pack_mv;
        logic signed [15:0] pack_ma;
        logic signed [15:0] temp_c;
        logic               chg_flag;
        logic [31:0]        now_ms;
        logic               force_req;
    } pack_sample_t;

    typedef struct packed {
        logic               polled;
        logic signed [22:0] pack_mw;
        logic               chg_active;
        logic [31:0]        drained_mwh;
        logic [15:0]        session_cnt;
        logic signed [15:0] max_temp_out;
        logic signed [15:0] max_in_ma;
        logic [14:0]        max_out_ma;
        logic [22:0]        up_secs;
        logic               ring_full;
    } pack_stats_t;

    typedef struct packed {
        pack_sample_t smp;
        logic         pin;
        pack_stats_t  want;
    } script_row_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        pack_mv = '0;
    logic signed [15:0] pack_ma = '0;
    logic signed [15:0] temp_c = '0;
    logic               chg_flag = 1'b0;
    logic [31:0]        now_ms = '0;
    logic               force_req = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               polled;
    logic signed [22:0] pack_mw;
    logic               chg_active;
    logic [31:0]        drained_mwh;
    logic [15:0]        session_cnt;
    logic signed [15:0] max_temp_out;
    logic signed [15:0] max_in_ma;
    logic [14:0]        max_out_ma;
    logic [22:0]        up_secs;
    logic               ring_full;

    battery_energy_stats_tracker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pack_mv        (pack_mv),
        .pack_ma        (pack_ma),
        .temp_c         (temp_c),
        .chg_flag       (chg_flag),
        .now_ms         (now_ms),
        .force_req      (force_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .polled         (polled),
        .pack_mw        (pack_mw),
        .chg_active     (chg_active),
        .drained_mwh    (drained_mwh),
        .session_cnt    (session_cnt),
        .max_temp_out   (max_temp_out),
        .max_in_ma      (max_in_ma),
        .max_out_ma     (max_out_ma),
        .up_secs        (up_secs),
        .ring_full      (ring_full)
    );

    // predicted tracker state
    logic [15:0]      ps_interval = 16'd1000;
    logic [31:0]      ps_last_tick = '0;
    longint unsigned  ps_remainder = 0;
    logic [31:0]      ps_energy = '0;
    logic             ps_was_charging = 1'b0;
    logic [15:0]      ps_sessions = '0;
    int               ps_peak_temp = 0;
    int               ps_peak_in = 0;
    int               ps_peak_out = 0;
    int               ps_ring_pos = 0;
    logic             ps_ring_wrapped = 1'b0;

    pack_stats_t pending_stats[$];
    int          mismatch_count = 0;
    int          stall_left = 3;
    logic        quiet = 1'b0;
    logic [31:0] tick = '0;

    script_row_t directed_rows [23] = '{
        // reset state, all-zero sample
        '{'{16'd0, 16'sd0, 16'sd0, 1'b0, 32'd0, 1'b1}, 1'b1,
          '{1'b1, 23'sd0, 1'b0, 32'd0, 16'd0, 16'sd0, 16'sd0, 15'd0, 23'd0, 1'b0}},
        // full-scale charge, top of tick range
        '{'{16'd65535, 16'sd32767, 16'sd32767, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{1'b1, 23'sd2147385, 1'b1, 32'd0, 16'd1, 16'sd32767, 16'sd32767, 15'd0,
            23'd4294967, 1'b0}},
        // full-scale discharge: peak_out saturates, zero dt books nothing
        '{'{16'd65535, 16'sh8000, 16'sh8000, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{1'b1, -23'sd2147450, 1'b0, 32'd0, 16'd1, 16'sd32767, 16'sd32767, 15'd32767,
            23'd4294967, 1'b0}},
        '{'{16'd12000, -16'sd5000, 16'sd25, 1'b0, 32'd0, 1'b1}, 1'b0, '0},
        // last tick is zero: first poll, no energy
        '{'{16'd12000, -16'sd5000, 16'sd25, 1'b0, 32'd1000, 1'b0}, 1'b0, '0},
        '{'{16'd12000, -16'sd5000, 16'sd26, 1'b0, 32'd1999, 1'b0}, 1'b0, '0},
        '{'{16'd12000, -16'sd5000, 16'sd26, 1'b0, 32'd2000, 1'b0}, 1'b0, '0},
        '{'{16'd3700, -16'sd1, 16'sd20, 1'b0, 32'd2001, 1'b1}, 1'b0, '0},
        // long gap clamped to one interval, then exactly four intervals
        '{'{16'd3700, -16'sd20000, 16'sd30, 1'b0, 32'd7001, 1'b0}, 1'b0, '0},
        '{'{16'd3700, -16'sd20000, 16'sd30, 1'b0, 32'd11001, 1'b0}, 1'b0, '0},
        '{'{16'd4200, 16'sd1500, 16'sd35, 1'b0, 32'd12001, 1'b0}, 1'b0, '0},
        '{'{16'd4200, 16'sd1500, 16'sd35, 1'b1, 32'd13001, 1'b0}, 1'b0, '0},
        '{'{16'd4200, -16'sd800, 16'sd35, 1'b1, 32'd14001, 1'b0}, 1'b0, '0},
        '{'{16'd4200, -16'sd800, 16'sd35, 1'b0, 32'd15001, 1'b0}, 1'b0, '0},
        '{'{16'd4200, 16'sd0, 16'sd35, 1'b1, 32'd16001, 1'b0}, 1'b0, '0},
        '{'{16'd65535, -16'sd1, 16'sd0, 1'b0, 32'd17001, 1'b1}, 1'b0, '0},
        // power rounds to zero toward zero
        '{'{16'd999, -16'sd1, 16'sd0, 1'b0, 32'd18001, 1'b0}, 1'b0, '0},
        '{'{16'd0, 16'sh8000, -16'sd40, 1'b0, 32'd19001, 1'b0}, 1'b0, '0},
        // tick wraps modulo 2^32
        '{'{16'd5000, -16'sd3000, 16'sd10, 1'b0, 32'hFFFF_FF00, 1'b1}, 1'b0, '0},
        '{'{16'd5000, -16'sd3000, 16'sd10, 1'b0, 32'h0000_0300, 1'b0}, 1'b0, '0},
        '{'{16'd5000, -16'sd3000, 16'sd10, 1'b0, 32'h0000_0301, 1'b0}, 1'b0, '0},
        '{'{16'd5000, -16'sd3000, 16'sd10, 1'b1, 32'h0000_0301, 1'b1}, 1'b0, '0},
        '{'{16'd1, 16'sd1, 16'sd1, 1'b1, 32'h8000_0000, 1'b0}, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pack_stats_t predict_stats(input pack_sample_t s);
        pack_stats_t     r;
        logic [31:0]     gap_ms;
        longint          v_l;
        longint          i_l;
        longint          p_l;
        longint unsigned acc;
        int              ma_i;
        logic            chg_now;
        r = '0;
        gap_ms = s.now_ms - ps_last_tick;
        r.polled = s.force_req || (gap_ms >= 32'(ps_interval));
        if (r.polled)
        begin
            v_l = longint'(s.pack_mv);
            ma_i = int'($signed(s.pack_ma));
            i_l = longint'(ma_i);
            p_l = v_l * i_l / 1000;
            chg_now = s.chg_flag || (ma_i > 0);
            if (ps_last_tick != 0 && p_l < 0)
            begin
                if (gap_ms > 32'(ps_interval) * GAP_FACTOR)
                    gap_ms = 32'(ps_interval);
                acc = ps_remainder + longint'(-p_l) * gap_ms;
                ps_energy = ps_energy + 32'(acc / MWMS_IN_MWH);
                ps_remainder = acc % MWMS_IN_MWH;
            end
            ps_ring_pos = (ps_ring_pos + 1) % HIST_DEPTH;
            if (ps_ring_pos == 0)
                ps_ring_wrapped = 1'b1;
            if (chg_now && !ps_was_charging)
                ps_sessions = ps_sessions + 16'd1;
            ps_was_charging = chg_now;
            if ($signed(s.temp_c) > ps_peak_temp)
                ps_peak_temp = int'($signed(s.temp_c));
            if (ma_i > ps_peak_in)
                ps_peak_in = ma_i;
            if (ma_i < -ps_peak_out)
                ps_peak_out = (-ma_i > 32767) ? 32767 : -ma_i;
            ps_last_tick = s.now_ms;
            r.pack_mw = 23'(p_l);
            r.chg_active = chg_now;
        end
        r.drained_mwh = ps_energy;
        r.session_cnt = ps_sessions;
        r.max_temp_out = 16'(ps_peak_temp);
        r.max_in_ma = 16'(ps_peak_in);
        r.max_out_ma = 15'(ps_peak_out);
        r.up_secs = 23'(s.now_ms / MS_IN_S);
        r.ring_full = ps_ring_wrapped;
        return r;
    endfunction

    function automatic int idle_cycles();
        return quiet ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Mostly a plausible sample stream around the poll interval; some pure noise.
    function automatic pack_sample_t next_pack_sample();
        pack_sample_t s;
        int unsigned  iv;
        int unsigned  sel;
        iv = 32'(ps_interval);
        if ($urandom_range(0, 99) < 15)
        begin
            s.pack_mv = 16'($urandom);
            s.pack_ma = 16'($urandom);
            s.temp_c = 16'($urandom);
            s.chg_flag = 1'($urandom);
            s.now_ms = $urandom;
            s.force_req = 1'($urandom);
            tick = s.now_ms;
            return s;
        end
        sel = $urandom_range(0, 99);
        if (sel < 10)
            tick = tick;
        else if (sel < 30)
            tick = tick + ((iv == 0) ? 0 : $urandom_range(0, iv - 1));
        else if (sel < 80)
            tick = tick + $urandom_range(iv, GAP_FACTOR * iv);
        else if (sel < 93)
            tick = tick + GAP_FACTOR * iv + $urandom_range(1, 100000);
        else if (sel < 98)
            tick = tick + $urandom;
        else
            tick = '0;
        s.now_ms = tick;
        s.pack_mv = ($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(2500, 60000));
        sel = $urandom_range(0, 99);
        if (sel < 60)
            s.pack_ma = 16'(-$urandom_range(1, 32768));
        else if (sel < 85)
            s.pack_ma = 16'($urandom_range(1, 32767));
        else
            s.pack_ma = 16'($urandom);
        if ($urandom_range(0, 99) < 85)
            s.temp_c = 16'(int'($urandom_range(0, 140)) - 40);
        else
            s.temp_c = 16'($urandom);
        s.chg_flag = 1'($urandom_range(0, 1));
        s.force_req = ($urandom_range(0, 9) == 0);
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input pack_sample_t s, input int gap, input logic pin,
                               input pack_stats_t typed);
        pack_stats_t e;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pack_mv <= s.pack_mv;
        pack_ma <= s.pack_ma;
        temp_c <= s.temp_c;
        chg_flag <= s.chg_flag;
        now_ms <= s.now_ms;
        force_req <= s.force_req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        e = predict_stats(s);
        if (pin)
            e = typed;
        pending_stats.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_stats.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_poll_interval(input logic [15:0] v);
        drain_results(20);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        ps_interval = v;
    endtask

    task automatic cmp_field(input string nm, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", nm, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        pack_stats_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $error("result with no request pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_stats.pop_front();
                cmp_field("polled", want.polled, polled);
                cmp_field("pack_mw", $signed(want.pack_mw), pack_mw);
                cmp_field("chg_active", want.chg_active, chg_active);
                cmp_field("drained_mwh", want.drained_mwh, drained_mwh);
                cmp_field("session_cnt", want.session_cnt, session_cnt);
                cmp_field("max_temp_out", $signed(want.max_temp_out), max_temp_out);
                cmp_field("max_in_ma", $signed(want.max_in_ma), max_in_ma);
                cmp_field("max_out_ma", want.max_out_ma, max_out_ma);
                cmp_field("up_secs", want.up_secs, up_secs);
                cmp_field("ring_full", want.ring_full, ring_full);
            end
            stall_left = idle_cycles();
        end
    end

    always @(negedge clk)
    begin
        // occasional stall not tied to a result
        if (stall_left == 0 && !quiet && $urandom_range(0, 19) == 0)
            stall_left = int'($urandom_range(1, 11));
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int unsigned iv_plan [7];
        iv_plan = '{1, 65535, 0, 250, 2, 7, 1000};
        iv_plan[4] = $urandom_range(2, 200);
        iv_plan[5] = $urandom_range(201, 65534);
        iv_plan[6] = $urandom_range(2, 40);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].smp, idle_cycles(), directed_rows[i].pin,
                        directed_rows[i].want);

        tick = 32'h8000_0000;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
                set_poll_interval(16'(iv_plan[ph - 1]));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % SEGMENT_ITEMS == 0)
                begin
                    quiet = ($urandom_range(0, 3) == 0);
                    if (n > 0 && $urandom_range(0, 2) == 0)
                        drain_results(0);
                end
                send_sample(next_pack_sample(), idle_cycles(), 1'b0, '0);
            end
        end

        drain_results(30);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
